@@ rtl/core/prn_pkg.sv @@
// Shared constants and types of the per-token RMS normalizer.
package prn_pkg;

  localparam int MAX_LEN     = 4096;
  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_CAP   = (MAX_LEN > 8191) ? 8191 : MAX_LEN;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 42;
  localparam int CNT_W    = 13;
  localparam int SCALE_W  = 37;
  localparam int EPS_W    = 16;
  localparam int OUT_W    = 28;
  localparam int MAG_W    = SAMPLE_BITS;
  localparam int PROD_W   = MAG_W + SCALE_W;

  // inverse root search widths
  localparam int M_W   = SUM_W + 1;
  localparam int RES_W = 73;
  localparam int Q_W   = M_W + 72;
  localparam int D_W   = RES_W + 1;
  localparam int STEP_W = 6;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic CFG_IDX_EPS = 1'b0;
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic signed [OUT_W-1:0] OUT_MAX = 28'sh7ffffff;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 28'sh8000000;

  typedef struct packed {
    logic               start;
    logic [SUM_W-1:0]   sum;
    logic [CNT_W-1:0]   count;
    logic [EPS_W-1:0]   eps;
  } solve_req_t;

  typedef struct packed {
    logic               done;
    logic [SCALE_W-1:0] scale;
  } solve_rsp_t;

endpackage

@@ rtl/core/prn_in_if.sv @@
// Input item channel: valid/ready handshake with the element payload.
interface prn_in_if;
  import prn_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_element;
  logic                       token_valid;

  modport source (output valid, kind, sample, last_element, token_valid, input ready);
  modport sink   (input valid, kind, sample, last_element, token_valid, output ready);
endinterface

@@ rtl/core/prn_out_if.sv @@
// Result item channel: valid/ready handshake with the normalized element.
interface prn_out_if;
  import prn_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] normalized;

  modport source (output valid, normalized, input ready);
  modport sink   (input valid, normalized, output ready);
endinterface

@@ rtl/core/prn_cfg.sv @@
// APB-style register block holding the epsilon offset.
module prn_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [prn_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [prn_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [prn_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output logic [prn_pkg::EPS_W-1:0]       eps
);
  import prn_pkg::*;

  logic [EPS_W-1:0] eps_r, eps_nxt;
  logic             wr_eps;

  // register index is the word address
  assign wr_eps = psel && penable && pwrite && (paddr[2] == CFG_IDX_EPS);

  always_comb begin
    eps_nxt = eps_r;
    if (wr_eps) begin
      eps_nxt = pwdata[EPS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else begin
      eps_r <= eps_nxt;
    end
  end

  assign prdata = (paddr[2] == CFG_IDX_EPS) ? {{(CFG_DATA_W-EPS_W){1'b0}}, eps_r}
                                            : '0;
  assign pready = 1'b1;
  assign eps    = eps_r;
endmodule

@@ rtl/core/prn_solve.sv @@
// Iterative mean and inverse square root unit with one shared adder and subtractor.
module prn_solve (
  input  logic                 clk,
  input  logic                 rst_n,
  input  prn_pkg::solve_req_t  req,
  output prn_pkg::solve_rsp_t  rsp
);
  import prn_pkg::*;

  localparam logic [2:0] SV_IDLE = 3'd0;
  localparam logic [2:0] SV_DIV  = 3'd1;
  localparam logic [2:0] SV_MEAN = 3'd2;
  localparam logic [2:0] SV_SUMD = 3'd3;
  localparam logic [2:0] SV_TEST = 3'd4;
  localparam logic [2:0] SV_DONE = 3'd5;

  localparam logic [STEP_W-1:0] DIV_LAST_STEP  = STEP_W'(SUM_W - 1);
  localparam logic [STEP_W-1:0] ROOT_LAST_STEP = STEP_W'(SCALE_W - 1);

  logic [2:0]         state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [SUM_W-1:0]   quo_r, quo_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [EPS_W-1:0]   eps_r, eps_nxt;
  logic [RES_W-1:0]   res_r, res_nxt;
  logic [RES_W-1:0]   p_r, p_nxt;
  logic [Q_W-1:0]     q_r, q_nxt;
  logic [D_W-1:0]     d_r, d_nxt;
  logic               d_ovf_r, d_ovf_nxt;
  logic [SCALE_W-1:0] s_r, s_nxt;

  logic [Q_W:0]       add_a, add_sum;
  logic [D_W-1:0]     sub_a, sub_b;
  logic [D_W:0]       sub_diff;
  logic               sub_ge;
  logic [SUM_W-1:0]   mean;
  logic [M_W-1:0]     m_val;
  logic               fit;

  // shared adder: P + Q while forming the trial delta, P/2 + Q when taking a bit
  always_comb begin
    if (state_r == SV_SUMD) begin
      add_a = (Q_W+1)'(p_r);
    end else begin
      add_a = (Q_W+1)'(p_r[RES_W-1:1]);
    end
  end
  assign add_sum = add_a + {1'b0, q_r};

  // shared subtractor: divider trial subtract or residual compare
  always_comb begin
    if (state_r == SV_DIV) begin
      sub_a = D_W'({rem_r, quo_r[SUM_W-1]});
      sub_b = D_W'(cnt_r);
    end else begin
      sub_a = D_W'(res_r);
      sub_b = d_r;
    end
  end
  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = !sub_diff[D_W];
  assign fit      = sub_ge && !d_ovf_r;

  assign mean  = (cnt_r == '0) ? '0 : quo_r;
  assign m_val = {1'b0, mean} + M_W'(eps_r);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    eps_nxt   = eps_r;
    res_nxt   = res_r;
    p_nxt     = p_r;
    q_nxt     = q_r;
    d_nxt     = d_r;
    d_ovf_nxt = d_ovf_r;
    s_nxt     = s_r;
    unique case (state_r)
      SV_IDLE: begin
        if (req.start) begin
          quo_nxt   = req.sum;
          rem_nxt   = '0;
          cnt_nxt   = req.count;
          eps_nxt   = req.eps;
          step_nxt  = DIV_LAST_STEP;
          state_nxt = SV_DIV;
        end
      end
      SV_DIV: begin
        // restoring division, one quotient bit a cycle
        rem_nxt = sub_ge ? sub_diff[CNT_W-1:0] : {rem_r[CNT_W-2:0], quo_r[SUM_W-1]};
        quo_nxt = {quo_r[SUM_W-2:0], sub_ge};
        if (step_r == '0) begin
          state_nxt = SV_MEAN;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      SV_MEAN: begin
        s_nxt = '0;
        if (m_val == '0) begin
          state_nxt = SV_DONE;
        end else begin
          // residual 2^72, P = s*m shifted, Q = m shifted by twice the bit index
          res_nxt   = {1'b1, {(RES_W-1){1'b0}}};
          p_nxt     = '0;
          q_nxt     = {m_val, {(Q_W-M_W){1'b0}}};
          step_nxt  = ROOT_LAST_STEP;
          state_nxt = SV_SUMD;
        end
      end
      SV_SUMD: begin
        d_nxt     = add_sum[D_W-1:0];
        d_ovf_nxt = |add_sum[Q_W:D_W];
        state_nxt = SV_TEST;
      end
      SV_TEST: begin
        if (fit) begin
          res_nxt = sub_diff[RES_W-1:0];
          p_nxt   = add_sum[RES_W-1:0];
        end else begin
          p_nxt   = {1'b0, p_r[RES_W-1:1]};
        end
        q_nxt = {2'b00, q_r[Q_W-1:2]};
        s_nxt = {s_r[SCALE_W-2:0], fit};
        if (step_r == '0) begin
          state_nxt = SV_DONE;
        end else begin
          step_nxt  = step_r - 1'b1;
          state_nxt = SV_SUMD;
        end
      end
      SV_DONE: begin
        state_nxt = SV_IDLE;
      end
      default: begin
        state_nxt = SV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r  <= step_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    eps_r   <= eps_nxt;
    res_r   <= res_nxt;
    p_r     <= p_nxt;
    q_r     <= q_nxt;
    d_r     <= d_nxt;
    d_ovf_r <= d_ovf_nxt;
    s_r     <= s_nxt;
  end

  assign rsp.done  = (state_r == SV_DONE);
  assign rsp.scale = s_r;
endmodule

@@ rtl/core/per_token_rms_normalize.sv @@
// Per-token RMS normalizer: two-pass streaming, shared multiplier and solve unit.
//
// Usage: the host sends each vector twice on in_item. Accumulate items
// (kind 0) add sample^2 into a saturating 42-bit sum; the one marked
// last_element closes the vector, forms m = floor(sum/count) + epsilon_raw
// and the scale floor(2^36/sqrt(m)). Apply items (kind 1) each return one
// out_item: sample*scale/2^16, saturated to 28 bits, zero for padding.
// epsilon_raw sits at APB byte address 0, reset value 1.
// One item is in flight at a time. Accumulate and apply items pass from
// accept through the 16x37 multiply to the sum update or the output format
// before the next item is accepted; an apply result is registered.
// A last_element item then also runs the restoring divider and the 37-bit
// inverse root search, a SV_SUMD and a SV_TEST state per bit on the shared
// adder/subtractor, plus handoff, before the next accept; the root search
// is skipped when m is zero.
// Reset clears the sum, count and scale (apply before any vector gives 0).
// A stalled out_item holds its result; the next item is still accepted and
// runs up to its output stage, where it waits for the register to free up.
module per_token_rms_normalize (
  input  logic                            clk,
  input  logic                            rst_n,
  prn_in_if.sink                          in_item,
  prn_out_if.source                       out_item,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [prn_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [prn_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [prn_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import prn_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_ACC   = 3'd2;
  localparam logic [2:0] ST_START = 3'd3;
  localparam logic [2:0] ST_SOLVE = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]                 state_r, state_nxt;
  logic                       kind_r, last_r, tok_r;
  logic signed [SAMPLE_W-1:0] x_r;
  logic [PROD_W-1:0]          prod_r, prod_nxt;
  logic [SUM_W-1:0]           sum_r, sum_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [SCALE_W-1:0]         scale_r, scale_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0]    out_norm_r, out_norm_nxt;

  logic                       in_fire;
  logic [MAG_W-1:0]           x_mag;
  logic [SCALE_W-1:0]         mul_b;
  logic [SUM_W:0]             acc_sum;
  logic [PROD_W:0]            mag_rnd;
  logic [PROD_W-16:0]         q_neg;
  logic [PROD_W-17:0]         q_pos;
  logic signed [OUT_W-1:0]    norm_val;
  logic                       out_free;
  logic [EPS_W-1:0]           eps;
  solve_req_t                 solve_req;
  solve_rsp_t                 solve_rsp;

  prn_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .eps     (eps)
  );

  prn_solve u_solve (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (solve_req),
    .rsp   (solve_rsp)
  );

  assign in_item.ready = (state_r == ST_IDLE);
  assign in_fire       = in_item.valid && in_item.ready;

  // shared multiplier: |x|*|x| for accumulate, |x|*scale for apply
  assign x_mag    = x_r[SAMPLE_W-1] ? MAG_W'(~x_r + 1'b1) : MAG_W'(x_r);
  assign mul_b    = kind_r ? scale_r : SCALE_W'(x_mag);
  assign prod_nxt = (state_r == ST_MUL) ? PROD_W'(x_mag) * PROD_W'(mul_b) : prod_r;

  assign acc_sum = {1'b0, sum_r} + (SUM_W+1)'(prod_r[2*MAG_W-1:0]);

  // floor of a negative product rounds the magnitude up
  assign mag_rnd = {1'b0, prod_r} + (PROD_W+1)'(16'hffff);
  assign q_neg   = mag_rnd[PROD_W:16];
  assign q_pos   = prod_r[PROD_W-1:16];

  always_comb begin
    if (!tok_r) begin
      norm_val = '0;
    end else if (x_r[SAMPLE_W-1]) begin
      if (q_neg > (PROD_W-15)'(134217728)) begin
        norm_val = OUT_MIN;
      end else begin
        norm_val = OUT_W'(~q_neg[OUT_W-1:0] + 1'b1);
      end
    end else begin
      if (q_pos > (PROD_W-16)'(134217727)) begin
        norm_val = OUT_MAX;
      end else begin
        norm_val = q_pos[OUT_W-1:0];
      end
    end
  end

  assign out_free = !out_valid_r || out_item.ready;

  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    scale_nxt     = scale_r;
    out_valid_nxt = out_valid_r && !out_item.ready;
    out_norm_nxt  = out_norm_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = kind_r ? ST_OUT : ST_ACC;
      end
      ST_ACC: begin
        if (count_r < CNT_W'(COUNT_CAP)) begin
          sum_nxt   = acc_sum[SUM_W] ? SUM_MAX : acc_sum[SUM_W-1:0];
          count_nxt = count_r + 1'b1;
        end
        state_nxt = last_r ? ST_START : ST_IDLE;
      end
      ST_START: begin
        state_nxt = ST_SOLVE;
      end
      ST_SOLVE: begin
        if (solve_rsp.done) begin
          scale_nxt = solve_rsp.scale;
          sum_nxt   = '0;
          count_nxt = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_norm_nxt  = norm_val;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign solve_req.start = (state_r == ST_START);
  assign solve_req.sum   = sum_r;
  assign solve_req.count = count_r;
  assign solve_req.eps   = eps;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      count_r     <= '0;
      scale_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      scale_r     <= scale_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // only the low SAMPLE_BITS bits of a sample carry the value
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r <= in_item.kind;
      x_r    <= SAMPLE_W'($signed(in_item.sample[SAMPLE_BITS-1:0]));
      last_r <= in_item.last_element;
      tok_r  <= in_item.token_valid;
    end
    prod_r     <= prod_nxt;
    out_norm_r <= out_norm_nxt;
  end

  assign out_item.valid      = out_valid_r;
  assign out_item.normalized = out_norm_r;
endmodule

@@ rtl/core/prn_checker.sv @@
// Port-level checks of the normalizer, bound onto the top level.
module prn_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           in_kind,
  input logic                           in_token_valid,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [prn_pkg::OUT_W-1:0] out_normalized
);
  import prn_pkg::*;

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_normalized)))
    else $error("result changed or dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("item accepted while previous item in flight");

  a_apply_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_kind && !out_valid) |=> !out_valid ##1 !out_valid ##1 out_valid)
    else $error("apply item result not delivered on time");

  a_padding_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_kind && !in_token_valid && !out_valid) |=> ##2 (out_normalized == '0))
    else $error("padding item produced nonzero result");

  a_acc_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_kind && !out_valid) |=> !out_valid ##1 !out_valid ##1 !out_valid)
    else $error("accumulate item produced a result");
endmodule

bind per_token_rms_normalize prn_checker u_prn_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_item.valid),
  .in_ready       (in_item.ready),
  .in_kind        (in_item.kind),
  .in_token_valid (in_item.token_valid),
  .out_valid      (out_item.valid),
  .out_ready      (out_item.ready),
  .out_normalized (out_item.normalized)
);

@@ sim/tb_per_token_rms_normalize.sv @@
// Self-checking testbench for the per-token RMS normalizer: directed cases, then random vectors.
`timescale 1ns / 100ps

module tb_per_token_rms_normalize;
  import prn_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SOLVE_DRAIN  = 200;  // covers divider plus root search after a last item
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 800;
  localparam int PHASES       = 8;
  localparam int LONG_LEN     = COUNT_CAP + 8;
  localparam logic [CFG_ADDR_W-1:0] EPS_ADDR = CFG_ADDR_W'(4 * CFG_IDX_EPS);

  localparam bit KIND_ACC   = 1'b0;
  localparam bit KIND_APPLY = 1'b1;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7fff;

  typedef longint unsigned u64_t;
  typedef enum int {STY_FULL, STY_SMALL, STY_CONST, STY_ZERO, STY_EXTREME} sample_style_t;

  class norm_scoreboard;
    logic [EPS_W-1:0]        eps;
    logic [SUM_W-1:0]        sq_sum;
    logic [CNT_W-1:0]        elem_cnt;
    logic [SCALE_W-1:0]      inv_scale;
    logic signed [OUT_W-1:0] pending_norm[$];
    int errors, checked, closed, sum_sats, capped, zero_scales, clipped, padded;

    function new();
      eps = EPS_RESET;
      sq_sum = '0;
      elem_cnt = '0;
      inv_scale = '0;
      errors = 0; checked = 0; closed = 0; sum_sats = 0;
      capped = 0; zero_scales = 0; clipped = 0; padded = 0;
    endfunction

    function void flag(string what, longint want, longint got);
      errors++;
      if (errors <= 10) $display("ERROR %s: expected %0d, got %0d", what, want, got);
    endfunction

    // largest s below 2^37 with s*s*m <= 2^72, i.e. floor(2^36/sqrt(m))
    function logic [SCALE_W-1:0] inv_root(logic [M_W-1:0] m);
      logic [SCALE_W-1:0] s;
      logic [SCALE_W-1:0] c;
      logic [127:0]       p;
      s = '0;
      if (m == 0) return s;
      for (int b = SCALE_W - 1; b >= 0; b--) begin
        c = s;
        c[b] = 1'b1;
        p = 128'(c) * 128'(c) * 128'(m);
        if (p <= (128'd1 << 72)) s = c;
      end
      return s;
    endfunction

    function void note_input(bit kind, logic signed [SAMPLE_W-1:0] sample, bit last, bit tok);
      logic signed [SAMPLE_W-1:0] t;
      longint                     x;
      u64_t                       nsum, mag, q;
      logic [M_W-1:0]             m;
      logic signed [OUT_W-1:0]    r;
      t = sample <<< (SAMPLE_W - SAMPLE_BITS);
      x = t;
      x = x >>> (SAMPLE_W - SAMPLE_BITS);
      if (kind == KIND_ACC) begin
        if (elem_cnt < COUNT_CAP) begin
          nsum = u64_t'(sq_sum) + u64_t'(x * x);
          if (nsum > u64_t'(SUM_MAX)) begin
            sq_sum = SUM_MAX;
            sum_sats++;
          end else begin
            sq_sum = SUM_W'(nsum);
          end
          elem_cnt++;
        end else begin
          capped++;
        end
        if (last) begin
          m = '0;
          if (elem_cnt != 0) m = M_W'(sq_sum) / M_W'(elem_cnt);
          m = m + M_W'(eps);
          inv_scale = inv_root(m);
          if (inv_scale == 0) zero_scales++;
          sq_sum = '0;
          elem_cnt = '0;
          closed++;
        end
        return;
      end
      r = '0;
      if (tok) begin
        mag = u64_t'(x < 0 ? -x : x) * u64_t'(inv_scale);
        if (x < 0) begin
          // floor of a negative quotient
          q = (mag + 65535) >> 16;
          if (q > (u64_t'(1) << (OUT_W - 1))) begin
            r = OUT_MIN;
            clipped++;
          end else begin
            r = OUT_W'(-longint'(q));
          end
        end else begin
          q = mag >> 16;
          if (q > u64_t'(OUT_MAX)) begin
            r = OUT_MAX;
            clipped++;
          end else begin
            r = OUT_W'(q);
          end
        end
      end else begin
        padded++;
      end
      pending_norm.push_back(r);
    endfunction

    function void check_result(logic signed [OUT_W-1:0] got);
      logic signed [OUT_W-1:0] want;
      if (pending_norm.size() == 0) begin
        flag("result with nothing pending", 0, got);
        return;
      end
      want = pending_norm.pop_front();
      checked++;
      if (got !== want) flag("normalized", want, got);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  psel, penable, pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata, prdata;
  logic                  pready;

  prn_in_if  in_ch();
  prn_out_if out_ch();

  norm_scoreboard sb = new();
  bit calm = 1'b0;
  int stall_asks = 0;
  int stall_done = 0;
  int items_sent = 0;

  per_token_rms_normalize dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch),
    .out_item (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.normalized);
  end

  // result side: random backpressure, plus long hold-offs on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_asks != stall_done) begin
        stall_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 30);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles", CYCLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic send_item(bit kind, logic signed [SAMPLE_W-1:0] sample, bit last, bit tok);
    while (!calm && $urandom_range(99) < 30) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= kind;
    in_ch.sample       <= sample;
    in_ch.last_element <= last;
    in_ch.token_valid  <= tok;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(kind, sample, last, tok);
    items_sent++;
    @(negedge clk);
  endtask

  // drain results, then give a closing solve time to finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending_norm.size() != 0) @(negedge clk);
    repeat (SOLVE_DRAIN) @(negedge clk);
  endtask

  task automatic read_epsilon();
    logic [CFG_DATA_W-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= EPS_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== CFG_DATA_W'(sb.eps)) sb.flag("epsilon_raw readback", sb.eps, got);
  endtask

  task automatic set_epsilon(logic [EPS_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= EPS_ADDR;
    pwdata  <= CFG_DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.eps = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    read_epsilon();
  endtask

  function automatic logic signed [SAMPLE_W-1:0] draw_sample(sample_style_t sty, int k,
                                                             logic signed [SAMPLE_W-1:0] base);
    int v;
    case (sty)
      STY_SMALL: begin
        v = int'($urandom_range(0, (2 << k) - 1)) - (1 << k);
        return SAMPLE_W'(v);
      end
      STY_CONST: return base;
      STY_ZERO:  return '0;
      STY_EXTREME: begin
        case ($urandom_range(2))
          0:       return S_MIN;
          1:       return S_MAX;
          default: return -S_MAX;
        endcase
      end
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // one vector: accumulate pass closed by a last item, then its apply pass
  task automatic run_vector(int len, sample_style_t sty);
    logic signed [SAMPLE_W-1:0] vec[$];
    logic signed [SAMPLE_W-1:0] base;
    int k, apply_len;
    k = $urandom_range(0, 14);
    base = SAMPLE_W'($urandom);
    for (int i = 0; i < len; i++) vec.push_back(draw_sample(sty, k, base));
    for (int i = 0; i < len; i++)
      send_item(KIND_ACC, vec[i], i == len - 1, $urandom_range(1));
    apply_len = ($urandom_range(9) == 0) ? $urandom_range(1, len + 4) : len;
    for (int i = 0; i < apply_len; i++)
      send_item(KIND_APPLY, (i < len) ? vec[i] : SAMPLE_W'($urandom), $urandom_range(1),
                $urandom_range(9) != 0);
  endtask

  task automatic random_phase(int budget);
    int start, r, len;
    start = items_sent;
    while (items_sent - start < budget) begin
      if ($urandom_range(4) == 0) begin
        // loose items: stray last marks, applies out of order
        repeat ($urandom_range(1, 6))
          send_item($urandom_range(1), SAMPLE_W'($urandom), $urandom_range(7) == 0,
                    $urandom_range(1));
      end else begin
        r = $urandom_range(99);
        if (r < 70)      len = $urandom_range(1, 16);
        else if (r < 95) len = $urandom_range(17, 64);
        else             len = $urandom_range(65, 300);
        run_vector(len, sample_style_t'($urandom_range(0, 4)));
      end
    end
  endtask

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.kind         = KIND_ACC;
    in_ch.sample       = '0;
    in_ch.last_element = 1'b0;
    in_ch.token_valid  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    read_epsilon();

    // scale is zero until the first vector closes
    send_item(KIND_APPLY, S_MAX, 1'b0, 1'b1);
    send_item(KIND_APPLY, S_MIN, 1'b1, 1'b1);
    // all-zero vector with epsilon 1: m = 1, largest scale, full-scale outputs clip
    send_item(KIND_ACC, '0, 1'b1, 1'b0);
    send_item(KIND_APPLY, S_MAX, 1'b0, 1'b1);
    send_item(KIND_APPLY, S_MIN, 1'b0, 1'b1);
    send_item(KIND_APPLY, 16'sd1, 1'b0, 1'b1);
    send_item(KIND_APPLY, -16'sd1, 1'b0, 1'b1);
    send_item(KIND_APPLY, '0, 1'b0, 1'b1);
    send_item(KIND_APPLY, S_MAX, 1'b0, 1'b0);
    send_item(KIND_APPLY, -16'sd7, 1'b1, 1'b1);
    // token_valid on accumulate items is ignored
    send_item(KIND_ACC, S_MIN, 1'b0, 1'b1);
    send_item(KIND_ACC, S_MAX, 1'b0, 1'b0);
    send_item(KIND_ACC, 16'sd5, 1'b1, 1'b1);
    send_item(KIND_APPLY, S_MIN, 1'b0, 1'b1);
    send_item(KIND_APPLY, S_MAX, 1'b0, 1'b1);
    send_item(KIND_APPLY, 16'sd5, 1'b0, 1'b1);
    send_item(KIND_APPLY, -16'sd3, 1'b0, 1'b1);
    send_item(KIND_APPLY, S_MIN, 1'b0, 1'b0);

    settle();
    set_epsilon('0);
    // zero mean square: scale 0
    send_item(KIND_ACC, '0, 1'b0, 1'b0);
    send_item(KIND_ACC, '0, 1'b1, 1'b0);
    send_item(KIND_APPLY, 16'sd1000, 1'b0, 1'b1);
    send_item(KIND_APPLY, -16'sd1000, 1'b0, 1'b1);
    // overlong full-scale vector: sum saturates, count stops at the cap
    for (int i = 0; i < LONG_LEN; i++) send_item(KIND_ACC, S_MIN, i == LONG_LEN - 1, 1'b0);
    send_item(KIND_APPLY, S_MIN, 1'b0, 1'b1);
    send_item(KIND_APPLY, S_MAX, 1'b0, 1'b1);
    send_item(KIND_APPLY, 16'sd12345, 1'b0, 1'b1);
    send_item(KIND_APPLY, -16'sd1, 1'b0, 1'b1);

    settle();
    set_epsilon(16'hffff);
    run_vector(8, STY_SMALL);
    send_item(KIND_ACC, 16'sd1, 1'b1, 1'b0);
    send_item(KIND_APPLY, S_MAX, 1'b0, 1'b1);
    send_item(KIND_APPLY, S_MIN, 1'b0, 1'b1);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0:       set_epsilon('0);
        1:       set_epsilon(16'hffff);
        2:       set_epsilon(EPS_W'($urandom_range(0, 15)));
        default: set_epsilon(EPS_W'($urandom));
      endcase
      calm = (ph == 3);
      if (ph == 5) begin
        // results back up while applies keep coming
        stall_asks++;
        repeat (20) send_item(KIND_APPLY, SAMPLE_W'($urandom), $urandom_range(1), 1'b1);
      end
      random_phase(RANDOM_ITEMS / PHASES);
    end
    calm = 1'b0;

    settle();
    $display("Sent %0d items over %0d closed vectors; %0d results checked, %0d padding",
             items_sent, sb.closed, sb.checked, sb.padded);
    $display("Saturated sums %0d, capped elements %0d, zero scales %0d, clipped outputs %0d",
             sb.sum_sats, sb.capped, sb.zero_scales, sb.clipped);
    if (sb.errors == 0 && sb.pending_norm.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Errors: %0d, results never seen: %0d", sb.errors, sb.pending_norm.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/prn_pkg.sv
rtl/core/prn_in_if.sv
rtl/core/prn_out_if.sv
rtl/core/prn_cfg.sv
rtl/core/prn_solve.sv
rtl/core/per_token_rms_normalize.sv
rtl/core/prn_checker.sv
sim/tb_per_token_rms_normalize.sv
